// File: rtl/core/tcem_pkg.sv
// Shared types, widths and codes for the timed channel event monitor.
// Used by every module of the block but tcem_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcem_pkg;

    // Field and register widths fixed by the interface.
    localparam int OP_W       = 2;
    localparam int MASK_W     = 8;
    localparam int IDX_W      = 3;
    localparam int PLAN_W     = 24;
    localparam int KIND_W     = 2;
    localparam int TICK_W     = 32;
    localparam int LATE_W     = 16;
    localparam int START_W    = 27;
    localparam int MARGIN_W   = 16;
    localparam int FLIGHT_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Derived widths of the time arithmetic.
    localparam int DUE_W   = START_W + 1;
    localparam int DUEM_W  = START_W + 2;
    localparam int LIMIT_W = START_W + 1;

    localparam int EVENT_SLOTS_DEF = 8;

    // Ticks past the end of the flight before monitoring stops.
    localparam int END_SLACK = 100;

    // Configuration reset values.
    localparam logic [START_W-1:0]  START_DELAY_RST = '0;
    localparam logic [MARGIN_W-1:0] FAIL_MARGIN_RST = MARGIN_W'(100);
    localparam logic [FLIGHT_W-1:0] FLIGHT_LEN_RST  = '0;
    localparam logic [MASK_W-1:0]   SYNC_SEL_RST    = 8'h80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SEL    = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_OK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAIL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STOP   = 2'd2,
        OP_REARM  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAMPLE,
        S_LOAD,
        S_STOP,
        S_REARM,
        S_RD,
        S_DUE,
        S_EVAL,
        S_TICK,
        S_FIN,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic sample_upd;
        logic load_wr;
        logic rearm;
        logic stop_end;
        logic slot_clr;
        logic slot_inc;
        logic due_ld;
        logic ev_emit;
        logic tick_inc;
        logic fin_chk;
        logic stat_emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic done;
        logic hit;
        logic out_free;
        logic last_slot;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/timed_channel_event_monitor_unit.sv
// Top level of the timed channel event monitor.
// Depends on tcem_pkg, tcem_ctrl, tcem_datapath and tcem_ram.
`timescale 1ns / 1ps
`default_nettype none

// The block watches an 8-bit channel sample once per millisecond tick and
// resolves a table of scheduled events against it.
//
// Request channel (req_valid / req_stall): one item carries an operation
// and its fields: a sample tick, a table load, a stop or a rearm. An item is
// taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall): every item yields zero or more
// event results (ok or fail, in slot order) and then one status or
// acknowledge result marked by last.
// The user must write configuration (cfg_wr_en / cfg_index / cfg_data)
// only while idle, unenforced by the block; writes take effect at once.
//
// Sequence: a load or a rearm passes through its own state and then the
// emit state before the next acceptance. A sample or a stop walks every
// event slot in turn: each slot is read from the table RAM, has its due
// time added up in a state of its own and is then judged. A sample that
// arrives after the end of monitoring skips the walk.
// When the receiver stalls, the single result register holds its item and
// the walk waits until it drains; the request side stays stalled meanwhile.
// Reset clears the run state, the configuration to its defaults and the
// table to untracked entries; no clearing pass is needed.

module timed_channel_event_monitor_unit import tcem_pkg::*; #(
    parameter int EVENT_SLOTS = EVENT_SLOTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [MASK_W-1:0]     sample_mask,
    input  wire logic [IDX_W-1:0]      entry_index,
    input  wire logic [PLAN_W-1:0]     entry_plan_ms,
    input  wire logic [MASK_W-1:0]     entry_need_mask,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic [KIND_W-1:0]          kind,
    output logic [IDX_W-1:0]           event_index,
    output logic [TICK_W-1:0]          event_tick,
    output logic [LATE_W-1:0]          lateness_ms,
    output logic [MASK_W-1:0]          latched_channels,
    output logic [MASK_W-1:0]          fresh_channels,
    output logic                       is_started,
    output logic                       sync_valid,
    output logic [TICK_W-1:0]          sync_tick_out,
    output logic                       flight_over,
    output logic                       last
);

    cmd_t  cmd;
    stat_t stat;

    // The controller decides on the next state from the raw operation code.
    tcem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (op_t'(operation)),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tcem_datapath #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .sample_mask      (sample_mask),
        .entry_index      (entry_index),
        .entry_plan_ms    (entry_plan_ms),
        .entry_need_mask  (entry_need_mask),
        .cmd              (cmd),
        .stat             (stat),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .kind             (kind),
        .event_index      (event_index),
        .event_tick       (event_tick),
        .lateness_ms      (lateness_ms),
        .latched_channels (latched_channels),
        .fresh_channels   (fresh_channels),
        .is_started       (is_started),
        .sync_valid       (sync_valid),
        .sync_tick_out    (sync_tick_out),
        .flight_over      (flight_over),
        .last             (last)
    );

endmodule

`default_nettype wire

// File: rtl/core/tcem_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the event table.
`timescale 1ns / 1ps
`default_nettype none

module tcem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tcem_ctrl.sv
// Controller state machine of the event monitor: sequences each item.
// Depends on tcem_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module tcem_ctrl import tcem_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    input  wire op_t   req_op,
    output logic       req_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_op)
                        OP_SAMPLE: state_next = S_SAMPLE;
                        OP_LOAD:   state_next = S_LOAD;
                        OP_STOP:   state_next = S_STOP;
                        OP_REARM:  state_next = S_REARM;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SAMPLE: state_next = stat.done ? S_EMIT : S_RD;
            S_LOAD:   state_next = S_EMIT;
            S_REARM:  state_next = S_EMIT;
            S_STOP:   state_next = S_RD;
            S_RD:     state_next = S_DUE;
            S_DUE:    state_next = S_EVAL;
            S_EVAL:
            begin
                if (!(stat.hit && !stat.out_free))
                begin
                    if (!stat.last_slot)
                    begin
                        state_next = S_RD;
                    end
                    else if (stat.op == OP_STOP)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_TICK;
                    end
                end
            end
            S_TICK:   state_next = S_FIN;
            S_FIN:    state_next = S_EMIT;
            S_EMIT:   state_next = stat.out_free ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            S_SAMPLE:
            begin
                cmd.sample_upd = !stat.done;
                cmd.slot_clr   = 1'b1;
            end
            S_LOAD:  cmd.load_wr = 1'b1;
            S_REARM: cmd.rearm = 1'b1;
            S_STOP:
            begin
                cmd.stop_end = 1'b1;
                cmd.slot_clr = 1'b1;
            end
            S_DUE:   cmd.due_ld = 1'b1;
            S_EVAL:
            begin
                if (!(stat.hit && !stat.out_free))
                begin
                    cmd.ev_emit  = stat.hit;
                    cmd.slot_inc = !stat.last_slot;
                end
            end
            S_TICK:  cmd.tick_inc = 1'b1;
            S_FIN:   cmd.fin_chk = 1'b1;
            S_EMIT:  cmd.stat_emit = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/tcem_datapath.sv
// Datapath of the event monitor: configuration, run state, event table
// walk and the result register. Depends on tcem_pkg and tcem_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcem_datapath import tcem_pkg::*; #(
    parameter int EVENT_SLOTS = EVENT_SLOTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [MASK_W-1:0]     sample_mask,
    input  wire logic [IDX_W-1:0]      entry_index,
    input  wire logic [PLAN_W-1:0]     entry_plan_ms,
    input  wire logic [MASK_W-1:0]     entry_need_mask,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output logic [KIND_W-1:0]          kind,
    output logic [IDX_W-1:0]           event_index,
    output logic [TICK_W-1:0]          event_tick,
    output logic [LATE_W-1:0]          lateness_ms,
    output logic [MASK_W-1:0]          latched_channels,
    output logic [MASK_W-1:0]          fresh_channels,
    output logic                       is_started,
    output logic                       sync_valid,
    output logic [TICK_W-1:0]          sync_tick_out,
    output logic                       flight_over,
    output logic                       last
);

    localparam int SLOT_W  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int ENTRY_W = PLAN_W + MASK_W;

    // Configuration.
    logic [START_W-1:0]  start_delay_reg;
    logic [MARGIN_W-1:0] fail_margin_reg;
    logic [FLIGHT_W-1:0] flight_len_reg;
    logic [MASK_W-1:0]   sync_sel_reg;

    // Captured item.
    op_t               op_reg;
    logic [MASK_W-1:0] sample_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [PLAN_W-1:0] plan_reg;
    logic [MASK_W-1:0] need_reg;

    // Run state.
    logic [TICK_W-1:0] tick_reg;
    logic [MASK_W-1:0] latch_reg;
    logic [MASK_W-1:0] fresh_reg;
    logic              started_reg;
    logic              seen_reg;
    logic [TICK_W-1:0] sync_tick_reg;
    logic              done_reg;

    // Event table bookkeeping.
    logic [EVENT_SLOTS-1:0] valid_reg;
    logic [EVENT_SLOTS-1:0] resolved_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [MASK_W-1:0]      need_q_reg;
    logic [DUE_W-1:0]       due_reg;
    logic [DUEM_W-1:0]      due_m_reg;
    logic [ENTRY_W-1:0]     rdata;

    // Result register.
    logic                rsp_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [IDX_W-1:0]    event_index_reg;
    logic [TICK_W-1:0]   event_tick_reg;
    logic [LATE_W-1:0]   lateness_reg;
    logic [MASK_W-1:0]   latched_reg;
    logic [MASK_W-1:0]   fresh_out_reg;
    logic                started_out_reg;
    logic                sync_valid_reg;
    logic [TICK_W-1:0]   sync_tick_out_reg;
    logic                over_reg;
    logic                last_reg;

    logic                in_range;
    logic [MASK_W-1:0]   fresh;
    logic                tracked;
    logic [TICK_W:0]     diff;
    logic                reached;
    logic                met;
    logic                past_margin;
    logic                hit;
    logic                hit_ok;
    logic [LATE_W-1:0]   late;
    logic [LIMIT_W-1:0]  limit;
    logic                out_free;

    assign in_range = 32'(index_reg) < 32'(EVENT_SLOTS);
    assign fresh    = sample_reg & ~latch_reg;

    tcem_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EVENT_SLOTS),
        .AW    (SLOT_W)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load_wr && in_range),
        .waddr (SLOT_W'(index_reg)),
        .wdata ({plan_reg, need_reg}),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // Decision for the slot under evaluation.
    assign tracked     = (need_q_reg != '0) && !resolved_reg[slot_reg];
    assign diff        = {1'b0, tick_reg} - (TICK_W + 1)'(due_reg);
    assign reached     = !diff[TICK_W];
    assign met         = (latch_reg & need_q_reg) == need_q_reg;
    assign past_margin = tick_reg >= TICK_W'(due_m_reg);
    assign hit_ok      = (op_reg != OP_STOP) && tracked && reached && met;
    assign hit         = (op_reg == OP_STOP) ? tracked
                                             : (tracked && reached && (met || past_margin));
    assign late        = (diff[TICK_W-1:LATE_W] != '0) ? '1 : diff[LATE_W-1:0];
    assign limit       = LIMIT_W'(start_delay_reg) + LIMIT_W'(flight_len_reg)
                         + LIMIT_W'(END_SLACK);
    assign out_free    = !rsp_valid_reg || !rsp_stall;

    assign stat.op        = op_reg;
    assign stat.done      = done_reg;
    assign stat.hit       = hit;
    assign stat.out_free  = out_free;
    assign stat.last_slot = slot_reg == SLOT_W'(EVENT_SLOTS - 1);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg <= START_DELAY_RST;
            fail_margin_reg <= FAIL_MARGIN_RST;
            flight_len_reg  <= FLIGHT_LEN_RST;
            sync_sel_reg    <= SYNC_SEL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_DELAY: start_delay_reg <= cfg_data[START_W-1:0];
                CFG_FAIL_MARGIN: fail_margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_FLIGHT_LEN:  flight_len_reg  <= cfg_data[FLIGHT_W-1:0];
                CFG_SYNC_SEL:    sync_sel_reg    <= cfg_data[MASK_W-1:0];
                default:         sync_sel_reg    <= sync_sel_reg;
            endcase
        end
    end

    // Captured payload and per-slot working values.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_mask;
            index_reg  <= entry_index;
            plan_reg   <= entry_plan_ms;
            need_reg   <= entry_need_mask;
        end
        if (cmd.due_ld)
        begin
            need_q_reg <= valid_reg[slot_reg] ? rdata[MASK_W-1:0] : '0;
            due_reg    <= DUE_W'(start_delay_reg) + DUE_W'(rdata[ENTRY_W-1:MASK_W]);
            due_m_reg  <= DUEM_W'(start_delay_reg) + DUEM_W'(rdata[ENTRY_W-1:MASK_W])
                          + DUEM_W'(fail_margin_reg);
        end
    end

    // Run state and table bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_SAMPLE;
            tick_reg      <= '0;
            latch_reg     <= '0;
            fresh_reg     <= '0;
            started_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            sync_tick_reg <= '0;
            done_reg      <= 1'b0;
            valid_reg     <= '0;
            resolved_reg  <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                op_reg    <= op_t'(operation);
                fresh_reg <= '0;
            end
            if (cmd.sample_upd)
            begin
                fresh_reg <= fresh;
                latch_reg <= latch_reg | fresh;
                if (!started_reg && (tick_reg >= TICK_W'(start_delay_reg)))
                begin
                    started_reg <= 1'b1;
                end
                if ((fresh & sync_sel_reg) != '0)
                begin
                    sync_tick_reg <= tick_reg;
                    seen_reg      <= 1'b1;
                end
            end
            if (cmd.load_wr && in_range)
            begin
                valid_reg[SLOT_W'(index_reg)]    <= 1'b1;
                resolved_reg[SLOT_W'(index_reg)] <= 1'b0;
            end
            if (cmd.rearm)
            begin
                tick_reg      <= '0;
                latch_reg     <= '0;
                started_reg   <= 1'b0;
                seen_reg      <= 1'b0;
                sync_tick_reg <= '0;
                done_reg      <= 1'b0;
                resolved_reg  <= '0;
            end
            // End of monitoring: on a stop, or once the flight window has passed.
            if (cmd.stop_end
                || (cmd.fin_chk && started_reg && (tick_reg > TICK_W'(limit))))
            begin
                done_reg <= 1'b1;
                if (!seen_reg && started_reg)
                begin
                    sync_tick_reg <= TICK_W'(start_delay_reg);
                    seen_reg      <= 1'b1;
                end
            end
            if (cmd.slot_clr)
            begin
                slot_reg <= '0;
            end
            else if (cmd.slot_inc)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            if (cmd.ev_emit)
            begin
                resolved_reg[slot_reg] <= 1'b1;
            end
            if (cmd.tick_inc && (tick_reg != '1))
            begin
                tick_reg <= tick_reg + 1'b1;
            end
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.ev_emit || cmd.stat_emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.ev_emit)
        begin
            kind_reg          <= hit_ok ? KIND_OK : KIND_FAIL;
            event_index_reg   <= IDX_W'(slot_reg);
            event_tick_reg    <= hit_ok ? tick_reg : '0;
            lateness_reg      <= hit_ok ? late : '0;
            latched_reg       <= '0;
            fresh_out_reg     <= '0;
            started_out_reg   <= 1'b0;
            sync_valid_reg    <= 1'b0;
            sync_tick_out_reg <= '0;
            over_reg          <= 1'b0;
            last_reg          <= 1'b0;
        end
        else if (cmd.stat_emit)
        begin
            kind_reg          <= (op_reg == OP_SAMPLE) ? KIND_STATUS : KIND_ACK;
            event_index_reg   <= '0;
            event_tick_reg    <= '0;
            lateness_reg      <= '0;
            latched_reg       <= latch_reg;
            fresh_out_reg     <= fresh_reg;
            started_out_reg   <= started_reg;
            sync_valid_reg    <= seen_reg;
            sync_tick_out_reg <= sync_tick_reg;
            over_reg          <= done_reg;
            last_reg          <= 1'b1;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign kind             = kind_reg;
    assign event_index      = event_index_reg;
    assign event_tick       = event_tick_reg;
    assign lateness_ms      = lateness_reg;
    assign latched_channels = latched_reg;
    assign fresh_channels   = fresh_out_reg;
    assign is_started       = started_out_reg;
    assign sync_valid       = sync_valid_reg;
    assign sync_tick_out    = sync_tick_out_reg;
    assign flight_over      = over_reg;
    assign last             = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/tcem_checker.sv
// Port-level checks of the event monitor, bound to the top level.
// Depends on tcem_pkg for widths and result kinds.
`timescale 1ns / 1ps
`default_nettype none

module tcem_checker import tcem_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_stall,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire logic [KIND_W-1:0] kind,
    input wire logic [TICK_W-1:0] event_tick,
    input wire logic [LATE_W-1:0] lateness_ms,
    input wire logic              last
);

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(kind) && $stable(last))
        else $error("stalled result changed");

    // Event results never close an item; status and acknowledge always do.
    a_event_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == KIND_OK || kind == KIND_FAIL) |-> !last)
        else $error("event result marked last");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (kind == KIND_STATUS || kind == KIND_ACK) |-> last)
        else $error("status result not marked last");

    // A failed event carries no timing.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && kind == KIND_FAIL |-> event_tick == '0 && lateness_ms == '0)
        else $error("fail result with timing");

    // An accepted item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken back to back");

endmodule

bind timed_channel_event_monitor_unit tcem_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .kind        (kind),
    .event_tick  (event_tick),
    .lateness_ms (lateness_ms),
    .last        (last)
);

`default_nettype wire
